// File: rtl/f32as_pkg.sv
// f32as_pkg: shared types and field constants for the float32 add/sub block
// no dependencies
package f32as_pkg;

	localparam int unsigned ExpW  = 8;
	localparam int unsigned FracW = 23;
	localparam int unsigned SigW  = 24;
	localparam int unsigned ShW   = 5;

	localparam logic [ExpW-1:0] ExpMax = 8'hFF;

	// signed sum after unpacking, alignment and add/subtract, handed to the normalize stage
	typedef struct packed {
		logic            zero;
		logic            sign;
		logic [SigW:0]   mag;
		logic [ExpW:0]   expo;
	} sum_t;

endpackage

// File: rtl/f32as_align.sv
// f32as_align: unpack, align and add/subtract the significands
// depends on f32as_pkg
module f32as_align (
	input  logic [31:0]       a_word,
	input  logic [31:0]       b_word,
	input  logic              mode,
	output f32as_pkg::sum_t   sum
);

	logic                      sa, sb, swap;
	logic [f32as_pkg::ExpW-1:0] ea, eb, el;
	logic [f32as_pkg::ExpW-1:0] d;
	logic [f32as_pkg::SigW-1:0] ma, mb, mbig, msml, msh;

	always_comb begin
		sa   = a_word[31];
		sb   = b_word[31] ^ mode;
		ea   = a_word[30:23];
		eb   = b_word[30:23];
		ma   = {1'b1, a_word[22:0]};
		mb   = {1'b1, b_word[22:0]};
		swap = (ea < eb);
		d    = swap ? (eb - ea) : (ea - eb);
		el   = swap ? eb : ea;
		mbig = swap ? mb : ma;
		msml = swap ? ma : mb;
		// gap of 24 or more clears the smaller significand
		msh  = (d > 8'd23) ? '0 : (msml >> d[f32as_pkg::ShW-1:0]);
		sum.expo = {1'b0, el};
		if (sa == sb) begin
			sum.mag  = {1'b0, mbig} + {1'b0, msh};
			sum.sign = sa;
		end else if ((swap ? msh : mbig) >= (swap ? mbig : msh)) begin
			sum.mag  = {1'b0, swap ? msh : mbig} - {1'b0, swap ? mbig : msh};
			sum.sign = sa;
		end else begin
			sum.mag  = {1'b0, swap ? mbig : msh} - {1'b0, swap ? msh : mbig};
			sum.sign = sb;
		end
		sum.zero = (sa != sb) && (sum.mag == '0);
	end

endmodule

// File: rtl/f32as_norm.sv
// f32as_norm: normalize, range check and pack the result word
// depends on f32as_pkg
module f32as_norm (
	input  f32as_pkg::sum_t sum,
	output logic [31:0]     result_word,
	output logic            overflow,
	output logic            underflow
);

	logic [f32as_pkg::ShW-1:0]  lz;
	logic [f32as_pkg::SigW-1:0] m;
	logic signed [f32as_pkg::ExpW+1:0] e;

	always_comb begin
		lz = '0;
		for (int i = 0; i < f32as_pkg::SigW; i++) begin
			if (sum.mag[i]) lz = f32as_pkg::ShW'(f32as_pkg::SigW - 1 - i);
		end
		if (sum.mag[f32as_pkg::SigW]) begin
			m = sum.mag[f32as_pkg::SigW:1];
			e = $signed({1'b0, sum.expo}) + 10'sd1;
		end else begin
			m = sum.mag[f32as_pkg::SigW-1:0] << lz;
			e = $signed({1'b0, sum.expo}) - $signed({5'd0, lz});
		end
		result_word = {sum.sign, e[7:0], m[22:0]};
		overflow    = 1'b0;
		underflow   = 1'b0;
		if (sum.zero) begin
			result_word = '0;
		end else if (e >= 10'sd255) begin
			result_word = {sum.sign, f32as_pkg::ExpMax, 23'd0};
			overflow    = 1'b1;
		end else if (e <= 10'sd0) begin
			result_word = {sum.sign, 31'd0};
			underflow   = 1'b1;
		end
	end

endmodule

// File: rtl/float32_add_sub.sv
// float32_add_sub: single-precision adder/subtractor, truncating, no rounding
// path from start to done: input register, then result register
// throughput: one word per cycle; busy is always low since results cannot stall
// reset: arst_n clears the valid pipeline only, payload registers are not reset
// depends on f32as_pkg, f32as_align, f32as_norm
module float32_add_sub (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] a_word,
	input  logic [31:0] b_word,
	input  logic        mode,
	output logic        done,
	output logic [31:0] result_word,
	output logic        overflow,
	output logic        underflow
);

	// input register
	logic        vld_s1;
	logic [31:0] a_s1, b_s1;
	logic        mode_s1;
	f32as_pkg::sum_t sum;
	logic [31:0] res_c;
	logic        ovf_c, unf_c;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			done   <= 1'b0;
		end else begin
			vld_s1 <= start;
			done   <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_s1    <= a_word;
			b_s1    <= b_word;
			mode_s1 <= mode;
		end
		// result register, loaded only with a live word
		if (vld_s1) begin
			result_word <= res_c;
			overflow    <= ovf_c;
			underflow   <= unf_c;
		end
	end

	// align and add or subtract magnitudes
	f32as_align u_align (
		.a_word(a_s1),
		.b_word(b_s1),
		.mode  (mode_s1),
		.sum   (sum)
	);

	// normalize and pack
	f32as_norm u_norm (
		.sum        (sum),
		.result_word(res_c),
		.overflow   (ovf_c),
		.underflow  (unf_c)
	);

`ifndef ASSERT_OFF
	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |=> done) else $error("done missing after stage 1");
	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(overflow && underflow)) else $error("both flags set");
	a_ovf_inf: assert property (@(posedge clk) disable iff (!arst_n)
		(done && overflow) |-> (result_word[30:0] == 31'h7F800000))
		else $error("overflow without infinity");
	a_unf_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && underflow) |-> (result_word[30:0] == 31'd0))
		else $error("underflow without zero");
`endif

endmodule
